@@ rtl/lscv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lscv_pkg
// shared types and constants of the line sensor calibrate and vote block
// ----------------------------------------------------------------------------
package lscv_pkg;

	localparam int LANES = 8;

	localparam logic MODE_CAL  = 1'b0;
	localparam logic MODE_MEAS = 1'b1;

	localparam logic KIND_MEAS = 1'b0;
	localparam logic KIND_CAL  = 1'b1;

	localparam int TDATA_W = 32;

	typedef logic [LANES-1:0] lane_t;

	typedef struct packed {
		logic  kind;
		lane_t voted_raw;
		lane_t line_bits;
		lane_t bg_pattern;
		logic  cal_ok;
	} lscv_res_t;

endpackage : lscv_pkg
`default_nettype wire

@@ rtl/lscv_cal.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lscv_cal
// per-channel high counters and white pattern latch for calibration
// ----------------------------------------------------------------------------
module lscv_cal #(
	parameter int CAL_SAMPLES = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           clear,
	input  wire logic           step,
	input  wire lscv_pkg::lane_t sample,
	output logic                done,
	output lscv_pkg::lane_t     new_pattern,
	output logic                new_ok,
	output lscv_pkg::lane_t     white_q,
	output logic                ok_q
);
	import lscv_pkg::*;

	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam int IDX_W = $clog2(CAL_SAMPLES);
	localparam logic [CNT_W-1:0] THRESH  = CNT_W'(CAL_SAMPLES / 2);
	localparam logic [IDX_W-1:0] IDX_END = IDX_W'(CAL_SAMPLES - 1);

	logic [CNT_W-1:0] cnt_q [LANES];
	logic [CNT_W-1:0] cnt_sum [LANES];
	logic [IDX_W-1:0] idx_q;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			cnt_sum[k]     = cnt_q[k] + CNT_W'(sample[k]);
			new_pattern[k] = (cnt_sum[k] >= THRESH);
		end
	end

	assign done   = step && (idx_q == IDX_END);
	assign new_ok = (new_pattern != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			for (int k = 0; k < LANES; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (clear || done) begin
			idx_q <= '0;
			for (int k = 0; k < LANES; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (step) begin
			idx_q <= idx_q + IDX_W'(1);
			for (int k = 0; k < LANES; k++) begin
				cnt_q[k] <= cnt_sum[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q <= '0;
			ok_q    <= 1'b0;
		end else if (done) begin
			white_q <= new_pattern;
			ok_q    <= new_ok;
		end
	end

endmodule : lscv_cal
`default_nettype wire

@@ rtl/lscv_vote.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lscv_vote
// holds two samples and forms the bitwise two-of-three majority on the third
// ----------------------------------------------------------------------------
module lscv_vote (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            clear,
	input  wire logic            step,
	input  wire lscv_pkg::lane_t sample,
	output logic                 emit,
	output lscv_pkg::lane_t      voted
);
	import lscv_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	phase_t phase_q;
	lane_t  held0_q;
	lane_t  held1_q;

	assign emit  = step && (phase_q == PH_THIRD);
	assign voted = (held0_q & held1_q) | (held0_q & sample) | (held1_q & sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
		end else if (clear) begin
			phase_q <= PH_FIRST;
		end else if (step) begin
			case (phase_q)
				PH_FIRST:  phase_q <= PH_SECOND;
				PH_SECOND: phase_q <= PH_THIRD;
				PH_THIRD:  phase_q <= PH_FIRST;
				default:   phase_q <= PH_FIRST;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step && (phase_q == PH_FIRST)) begin
			held0_q <= sample;
		end
		if (step && (phase_q == PH_SECOND)) begin
			held1_q <= sample;
		end
	end

endmodule : lscv_vote
`default_nettype wire

@@ rtl/line_sensor_calibrate_vote.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// line_sensor_calibrate_vote
// line sensor white calibration and two-of-three majority vote
// ----------------------------------------------------------------------------
// One sample beat is taken per clock when the result side keeps up: a beat
// is registered on entry, the counters or the vote logic act on it in a
// cycle in which the result register is free or being read, and any result
// is loaded into the output register at the end of that same cycle. In
// calibrate mode every CAL_SAMPLES beats give one calibration result; in
// measure mode every third beat gives one vote result. A mode write
// restarts both counters but keeps the latched white pattern. Sample bits
// at or above CHANNELS are ignored throughout.
module line_sensor_calibrate_vote #(
	parameter int CHANNELS    = 8,
	parameter int CAL_SAMPLES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,        // mode
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,    // sample
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [lscv_pkg::TDATA_W-1:0] m_axis_tdata,
	// voted_raw [7:0], line_bits [15:8], bg_pattern [23:16], cal_ok [24]
	output logic             m_axis_tuser     // kind
);
	import lscv_pkg::*;

	logic      mode_q;
	logic      cfg_wr;
	lane_t     chan_mask;
	logic      valid_s1;
	lane_t     sample_s1;
	logic      adv;
	logic      cal_step;
	logic      vote_step;
	logic      cal_done;
	lane_t     new_pattern;
	logic      new_ok;
	lane_t     white_q;
	logic      ok_q;
	logic      vote_emit;
	lane_t     voted;
	lscv_res_t res_d;
	lscv_res_t res_q;
	logic      res_valid_q;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			chan_mask[k] = (k < CHANNELS);
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CAL;
		end else if (cfg_wr) begin
			mode_q <= cfg_data;
		end
	end

	// entry stage
	assign adv           = valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1 <= s_axis_tdata & chan_mask;
		end
	end

	assign cal_step  = adv && (mode_q == MODE_CAL);
	assign vote_step = adv && (mode_q == MODE_MEAS);

	lscv_cal #(
		.CAL_SAMPLES(CAL_SAMPLES)
	) u_cal (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_wr),
		.step       (cal_step),
		.sample     (sample_s1),
		.done       (cal_done),
		.new_pattern(new_pattern),
		.new_ok     (new_ok),
		.white_q    (white_q),
		.ok_q       (ok_q)
	);

	lscv_vote u_vote (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (cfg_wr),
		.step  (vote_step),
		.sample(sample_s1),
		.emit  (vote_emit),
		.voted (voted)
	);

	always_comb begin
		if (cal_done) begin
			res_d.kind       = KIND_CAL;
			res_d.voted_raw  = '0;
			res_d.line_bits  = '0;
			res_d.bg_pattern = new_pattern;
			res_d.cal_ok     = new_ok;
		end else begin
			res_d.kind       = KIND_MEAS;
			res_d.voted_raw  = voted;
			res_d.line_bits  = voted ^ white_q;
			res_d.bg_pattern = white_q;
			res_d.cal_ok     = ok_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (res_valid_q && !m_axis_tready) || cal_done || vote_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cal_done || vote_emit) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {7'd0, res_q.cal_ok, res_q.bg_pattern,
		res_q.line_bits, res_q.voted_raw};

	a_cal_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == KIND_CAL)) |->
		(res_q.voted_raw == '0 && res_q.line_bits == '0 &&
		res_q.cal_ok == (res_q.bg_pattern != '0)))
		else $error("calibration beat payload inconsistent");

	a_meas_line: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == KIND_MEAS)) |->
		(res_q.line_bits == (res_q.voted_raw ^ res_q.bg_pattern)))
		else $error("line bits do not match vote and white pattern");

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(cal_done && vote_emit))
		else $error("calibration and vote produced a result together");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !adv)
		else $error("entry stage advanced into a full result register");

endmodule : line_sensor_calibrate_vote
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the line sensor calibrate and vote block
// ----------------------------------------------------------------------------
// Sample beats go in through the input stream and mode writes through the
// config channel. A scoreboard class keeps its own copy of the counters, the
// vote phase and the latched white pattern. From every accepted sample it
// works out the result that is due, and it checks each result beat against
// the oldest one, field by field. Directed phases cover voting before any
// calibration and a calibration that sits on the half-count boundary. Random
// phases then mix modes, repeated writes, partial runs, dark and bright
// backgrounds and noisy votes. Both sides of the stream stall at random, the
// result side also holds off for one long stretch, and a watchdog ends a
// stuck run.
module tb;
	import lscv_pkg::*;

	localparam int CHANNELS     = 8;
	localparam int CAL_SAMPLES  = 16;
	localparam int RANDOM_ITEMS = 450;
	localparam int IDLE_PCT     = 32;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT  = 4000;
	localparam int REPORT_MAX   = 10;

	localparam lane_t CH_MASK = lane_t'((64'd1 << CHANNELS) - 1);
	localparam lane_t VOTE_SET [9] = '{
		8'hFF, 8'h00, 8'h00,
		8'hFF, 8'hFF, 8'h00,
		8'hA5, 8'h5A, 8'h3C
	};

	class sensor_result_model;
		logic        mode;
		lane_t       white;
		logic        cal_flag;
		int unsigned hits [LANES];
		int unsigned cal_index;
		lane_t       held [2];
		int unsigned vote_phase;
		lscv_res_t   due_results [$];
		int unsigned mismatches;

		function new();
			mode       = MODE_CAL;
			white      = '0;
			cal_flag   = 1'b0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			for (int k = 0; k < LANES; k++)
				hits[k] = 0;
			cal_index  = 0;
			held[0]    = '0;
			held[1]    = '0;
			vote_phase = 0;
		endfunction

		function void write_mode(logic value);
			mode = value;
			restart();
		endfunction

		function void take_sample(lane_t raw);
			lane_t     s;
			lane_t     pat;
			lane_t     v;
			lscv_res_t r;
			s = raw & CH_MASK;
			if (mode == MODE_CAL) begin
				for (int k = 0; k < LANES; k++)
					if (s[k])
						hits[k]++;
				cal_index++;
				if (cal_index >= CAL_SAMPLES) begin
					pat = '0;
					for (int k = 0; k < LANES; k++)
						pat[k] = (hits[k] >= CAL_SAMPLES / 2);
					white    = pat & CH_MASK;
					cal_flag = (white != '0);
					for (int k = 0; k < LANES; k++)
						hits[k] = 0;
					cal_index    = 0;
					r.kind       = KIND_CAL;
					r.voted_raw  = '0;
					r.line_bits  = '0;
					r.bg_pattern = white;
					r.cal_ok     = cal_flag;
					due_results.push_back(r);
				end
			end else if (vote_phase < 2) begin
				held[vote_phase % 2] = s;
				vote_phase++;
			end else begin
				v = (held[0] & held[1]) | (held[0] & s) | (held[1] & s);
				vote_phase   = 0;
				r.kind       = KIND_MEAS;
				r.voted_raw  = v;
				r.line_bits  = v ^ white;
				r.bg_pattern = white;
				r.cal_ok     = cal_flag;
				due_results.push_back(r);
			end
		endfunction

		function string show(lscv_res_t r);
			return $sformatf("kind=%0d raw=%02h line=%02h bg=%02h ok=%0d",
				r.kind, r.voted_raw, r.line_bits, r.bg_pattern, r.cal_ok);
		endfunction

		function void report(string what, lscv_res_t want, lscv_res_t got);
			if (mismatches < REPORT_MAX)
				$display("%0t %s: expected %s, got %s",
					$time, what, show(want), show(got));
			mismatches++;
		endfunction

		function void check_beat(logic kind, logic [TDATA_W-1:0] data);
			lscv_res_t got;
			lscv_res_t want;
			got.kind       = kind;
			got.voted_raw  = data[7:0];
			got.line_bits  = data[15:8];
			got.bg_pattern = data[23:16];
			got.cal_ok     = data[24];
			if (due_results.size() == 0) begin
				want = '0;
				report("result with nothing due", want, got);
			end else begin
				want = due_results.pop_front();
				if (got.kind !== want.kind || got.voted_raw !== want.voted_raw ||
						got.line_bits !== want.line_bits ||
						got.bg_pattern !== want.bg_pattern ||
						got.cal_ok !== want.cal_ok)
					report("result mismatch", want, got);
			end
		endfunction

		function bit all_clear();
			return mismatches == 0 && due_results.size() == 0;
		endfunction
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_data      = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic                 m_axis_tuser;

	sensor_result_model   model;
	bit                   calm          = 1'b0;
	bit                   hold_req      = 1'b0;
	int unsigned          samples_sent  = 0;
	int unsigned          quiet_cycles  = 0;

	line_sensor_calibrate_vote #(
		.CHANNELS    (CHANNELS),
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	task automatic send_sample(input lane_t value);
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		model.take_sample(value);
		samples_sent++;
	endtask

	task automatic set_mode(input logic value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model.write_mode(value);
	endtask

	// sender pauses until every due result is back and the pipe has settled
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (model.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always begin
		@(posedge clk);
		if (m_axis_tvalid && m_axis_tready)
			model.check_beat(m_axis_tuser, m_axis_tdata);
		if (hold_req) begin
			m_axis_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL line_sensor_calibrate_vote");
				$finish;
			end
		end
	end

	initial begin
		lane_t       base;
		lane_t       s;
		int unsigned density [LANES];
		int unsigned n;
		int unsigned r;
		int unsigned phase_no;
		logic        m;
		model = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// voting before any calibration
		set_mode(MODE_MEAS);
		for (int i = 0; i < 9; i++)
			send_sample(VOTE_SET[i]);
		drain();

		// low nibble high 8 times, high nibble 7 times
		set_mode(MODE_CAL);
		for (int i = 0; i < CAL_SAMPLES; i++)
			send_sample(lane_t'((i < 8 ? 8'h0F : 8'h00) | (i < 7 ? 8'hF0 : 8'h00)));
		drain();

		phase_no = 0;
		while (samples_sent < 25 + RANDOM_ITEMS) begin
			phase_no++;
			calm = (phase_no >= 5 && phase_no <= 8);
			m = logic'($urandom_range(0, 1));
			if (phase_no == 2)
				m = MODE_MEAS;
			set_mode(m);
			if (phase_no == 2)
				hold_req = 1'b1;
			if (m == MODE_CAL) begin
				r = $urandom_range(0, 4);
				for (int k = 0; k < LANES; k++) begin
					if (r == 0)
						density[k] = 0;
					else if (r == 1)
						density[k] = 100;
					else begin
						n = $urandom_range(0, 3);
						density[k] = (n == 0) ? 0 : (n == 1) ? 100 : (n == 2) ? 50 :
							$urandom_range(0, 100);
					end
				end
				n = CAL_SAMPLES * $urandom_range(1, 2);
				if ($urandom_range(0, 3) == 0)
					n += $urandom_range(1, CAL_SAMPLES - 1);
				repeat (n) begin
					for (int k = 0; k < LANES; k++)
						s[k] = ($urandom_range(0, 99) < density[k]);
					send_sample(s);
				end
			end else begin
				n = (phase_no == 2) ? 60 : $urandom_range(3, 45);
				base = lane_t'($urandom);
				repeat (n) begin
					if ($urandom_range(0, 3) == 0)
						base = lane_t'($urandom);
					if ($urandom_range(0, 2) == 0)
						s = lane_t'($urandom);
					else
						s = base ^ (lane_t'($urandom) & lane_t'($urandom) & lane_t'($urandom));
					send_sample(s);
				end
			end
			drain();
		end
		calm = 1'b0;

		if (model.all_clear()) begin
			$display("PASS line_sensor_calibrate_vote");
		end else begin
			$display("FAIL line_sensor_calibrate_vote");
		end
		$finish;
	end

endmodule

@@ line_sensor_calibrate_vote.f @@
rtl/lscv_pkg.sv
rtl/lscv_cal.sv
rtl/lscv_vote.sv
rtl/line_sensor_calibrate_vote.sv
sim/tb.sv
